// ===== hw/rtl/avc_lp2sc_pkg.sv =====
// ----------------------------------------------------------------------------
// avc_lp2sc_pkg
// Beat types and parse codes for the length-prefixed to start-code converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package avc_lp2sc_pkg;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic [23:0] packet_length;
        logic        packet_end;
    } body_beat_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       unit_begin;
        logic       run_last;
    } stream_beat_t;

    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_LEN0    = 3'd1;
    localparam logic [2:0] PH_LEN1    = 3'd2;
    localparam logic [2:0] PH_LEN2    = 3'd3;
    localparam logic [2:0] PH_LEN3    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_COUNT   = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    localparam logic EMIT_START = 1'b0;
    localparam logic EMIT_BYTE  = 1'b1;

    localparam int unsigned MIN_PACKET      = 11;
    localparam int unsigned NALU_SKIP       = 5;
    localparam int unsigned CFG_SKIP        = 10;
    localparam logic [4:0]  SET_COUNT_MASK  = 5'h1f;
    localparam logic [7:0]  START_ZERO      = 8'h00;
    localparam logic [7:0]  START_ONE       = 8'h01;
    localparam logic [2:0]  START_BEATS     = 3'd4;

endpackage

// ===== hw/rtl/avc_length_prefixed_to_start_code_top.sv =====
// ----------------------------------------------------------------------------
// avc_length_prefixed_to_start_code_top
// Rewrites length-prefixed H.264 packet bodies as a start-code byte stream.
// ----------------------------------------------------------------------------
// channel   dir  payload        beat
// body      in   body_beat_t    one packet body byte
// stream    out  stream_beat_t  one Annex-B stream byte
//
// A body beat is parsed in the cycle it is accepted; its 0, 1 or 4 stream
// beats leave from the result register, one per cycle while stream_ready
// is high. Payload bytes pass at one beat per cycle when stream_ready stays
// high; a length field's last byte holds the body side while the start code
// drains. body_ready is high if no stream beat waits or the last one is taken.
// Reset clears parse state and result count, not data_reg; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avc_length_prefixed_to_start_code_top
    import avc_lp2sc_pkg::*;
#(
    parameter int BODY_LENGTH_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         body_valid,
    output logic         body_ready,
    input  body_beat_t   body,
    output logic         stream_valid,
    input  logic         stream_ready,
    output stream_beat_t stream
);

    localparam int PW = BODY_LENGTH_BITS;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    logic          pending_reg, pending_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]    phase_reg, phase_next;
    logic [31:0]   gather_reg, gather_next;
    logic [31:0]   left_reg, left_next;
    logic [4:0]    sets_reg, sets_next;
    logic          pic_reg, pic_next;

    logic          kind_reg, kind_next;
    logic [7:0]    data_reg, data_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [1:0]    idx_reg, idx_next;

    logic          body_take;
    logic          stream_take;
    logic [PW-1:0] plen;
    logic          parse_en;
    logic [7:0]    b;
    logic [4:0]    sets_dec;
    logic [31:0]   left_dec;
    logic [31:0]   len_full;
    logic [2:0]    emit_n;
    logic          emit_kind;

    assign stream_take  = stream_valid && stream_ready;
    assign stream_valid = (cnt_reg != 3'd0);
    assign body_ready   = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && stream_ready);
    assign body_take    = body_valid && body_ready;

    assign plen     = PW'(body.packet_length);
    assign b        = body.body_byte;
    assign parse_en = (plen >= PW'(MIN_PACKET)) && (pos_reg < plen);
    assign sets_dec = (sets_reg != 5'd0) ? ((sets_reg - 5'd1) & SET_COUNT_MASK) : 5'd0;
    assign left_dec = left_reg - 32'd1;
    assign len_full = {gather_reg[23:0], b};

    always_comb
    begin
        pending_next = pending_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        gather_next  = gather_reg;
        left_next    = left_reg;
        sets_next    = sets_reg;
        pic_next     = pic_reg;
        emit_n       = 3'd0;
        emit_kind    = EMIT_BYTE;

        if (parse_en)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (pending_reg)
                    begin
                        if (pos_reg >= PW'(CFG_SKIP - 1))
                            phase_next = PH_COUNT;
                    end
                    else if (pos_reg >= PW'(NALU_SKIP - 1))
                    begin
                        phase_next = PH_LEN0;
                    end
                end
                PH_COUNT:
                begin
                    sets_next = b[4:0] & SET_COUNT_MASK;
                    if ((b[4:0] & SET_COUNT_MASK) != 5'd0)
                        phase_next = PH_LEN2;
                    else if (!pic_reg)
                    begin
                        pic_next   = 1'b1;
                        phase_next = PH_COUNT;
                    end
                    else
                        phase_next = PH_DONE;
                end
                PH_LEN0:
                begin
                    gather_next = {24'd0, b};
                    phase_next  = PH_LEN1;
                end
                PH_LEN1:
                begin
                    gather_next = len_full;
                    phase_next  = PH_LEN2;
                end
                PH_LEN2:
                begin
                    gather_next = pending_reg ? {24'd0, b} : len_full;
                    phase_next  = PH_LEN3;
                end
                PH_LEN3, PH_PAYLOAD:
                begin
                    if (phase_reg == PH_LEN3)
                    begin
                        gather_next = len_full;
                        left_next   = len_full;
                        emit_n      = START_BEATS;
                        emit_kind   = EMIT_START;
                        phase_next  = PH_PAYLOAD;
                    end
                    else
                    begin
                        left_next = left_dec;
                        emit_n    = 3'd1;
                    end
                    if (((phase_reg == PH_LEN3) && (len_full == 32'd0)) ||
                        ((phase_reg == PH_PAYLOAD) && (left_dec == 32'd0)))
                    begin
                        if (!pending_reg)
                            phase_next = PH_LEN0;
                        else
                        begin
                            sets_next = sets_dec;
                            if (sets_dec != 5'd0)
                                phase_next = PH_LEN2;
                            else if (!pic_reg)
                            begin
                                pic_next   = 1'b1;
                                phase_next = PH_COUNT;
                            end
                            else
                                phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (body.packet_end)
        begin
            if (plen >= PW'(MIN_PACKET))
                pending_next = 1'b0;
            pos_next    = '0;
            phase_next  = PH_SKIP;
            gather_next = 32'd0;
            left_next   = 32'd0;
            sets_next   = 5'd0;
            pic_next    = 1'b0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + PW'(1);
        end
    end

    always_comb
    begin
        kind_next = kind_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (body_take)
        begin
            kind_next = emit_kind;
            data_next = b;
            cnt_next  = emit_n;
            idx_next  = 2'd0;
        end
        else if (stream_take)
        begin
            cnt_next = cnt_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b1;
            pos_reg     <= '0;
            phase_reg   <= PH_SKIP;
            gather_reg  <= 32'd0;
            left_reg    <= 32'd0;
            sets_reg    <= 5'd0;
            pic_reg     <= 1'b0;
            cnt_reg     <= 3'd0;
            idx_reg     <= 2'd0;
            kind_reg    <= EMIT_BYTE;
        end
        else
        begin
            if (body_take)
            begin
                pending_reg <= pending_next;
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                gather_reg  <= gather_next;
                left_reg    <= left_next;
                sets_reg    <= sets_next;
                pic_reg     <= pic_next;
            end
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        if (kind_reg == EMIT_START)
            stream.stream_byte = (idx_reg == 2'd3) ? START_ONE : START_ZERO;
        else
            stream.stream_byte = data_reg;
        stream.unit_begin = (kind_reg == EMIT_START) && (idx_reg == 2'd0);
        stream.run_last   = (cnt_reg == 3'd1);
    end

    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        body_ready |-> (cnt_reg <= 3'd1))
        else $error("body accepted with stream beats still queued");

    a_begin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stream_valid && stream.unit_begin) |->
            (stream.stream_byte == START_ZERO) && !stream.run_last && (cnt_reg == START_BEATS))
        else $error("start code beat out of place");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (stream_take && stream.run_last) |-> body_ready)
        else $error("last stream beat taken without freeing body side");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= START_BEATS) && ((kind_reg != EMIT_BYTE) || (cnt_reg <= 3'd1)))
        else $error("result count out of range");

endmodule

// ===== tb/avc_length_prefixed_to_start_code_top_tb.sv =====
// ----------------------------------------------------------------------------
// avc_length_prefixed_to_start_code_top_tb
// Self-checking bench for the length-prefixed to start-code converter.
// A short table of body beats walks the decoder configuration record, a short
// packet and a cut-off length field. Random packets follow: mostly well-formed
// unit lists with random content, plus short packets, truncated packets and
// noise. Every accepted body beat runs through a local parser model, and every
// stream beat is compared field by field with the oldest predicted beat. The
// sender and receiver idle at several mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avc_length_prefixed_to_start_code_top_tb;

    import avc_lp2sc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          PHASE_BEATS    = 48;
    localparam logic [23:0] MAX_POS        = 24'hFFFFFF;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_START} row_kind_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [23:0] len;
        logic        last;
        row_kind_t   kind;
    } dir_row_t;

    localparam int NUM_ROWS = 27;

    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'hFF, 24'd1,      1'b1, ROW_NONE},
        '{8'hFF, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'hFF, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'hFF, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'hFF, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'hFF, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'hE0, 24'd18,     1'b0, ROW_NONE},
        '{8'h02, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'h00, 24'd18,     1'b0, ROW_START},
        '{8'h00, 24'd18,     1'b0, ROW_NONE},
        '{8'h01, 24'd18,     1'b0, ROW_START},
        '{8'hAB, 24'd18,     1'b0, ROW_PRED},
        '{8'h5A, 24'd18,     1'b1, ROW_NONE},
        '{8'hFF, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'h00, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'hFF, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'h00, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'hFF, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'h00, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'h00, 24'hFFFFFF, 1'b0, ROW_NONE},
        '{8'hFF, 24'hFFFFFF, 1'b1, ROW_NONE}
    };

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         body_valid   = 1'b0;
    logic         body_ready;
    body_beat_t   body         = '0;
    logic         stream_valid;
    logic         stream_ready = 1'b0;
    stream_beat_t stream;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int idle_cycles     = 0;
    int mismatches      = 0;
    int beats_sent      = 0;
    int packets_sent    = 0;
    int beats_checked   = 0;
    int start_codes     = 0;

    stream_beat_t stream_expected [$];
    stream_beat_t step_results [$];
    body_beat_t   packet_q [$];

    logic        rec_pending;
    logic [23:0] at_pos;
    logic [2:0]  parse_ph;
    logic [31:0] len_acc;
    logic [31:0] pay_left;
    logic [4:0]  sets_left;
    logic        in_pps;

    avc_length_prefixed_to_start_code_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .body_valid   (body_valid),
        .body_ready   (body_ready),
        .body         (body),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream       (stream)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic clear_parser();
        at_pos    = '0;
        parse_ph  = PH_SKIP;
        len_acc   = '0;
        pay_left  = '0;
        sets_left = '0;
        in_pps    = 1'b0;
    endtask

    task automatic next_set();
        if (sets_left != 0)
            parse_ph = PH_LEN2;
        else if (!in_pps)
        begin
            in_pps   = 1'b1;
            parse_ph = PH_COUNT;
        end
        else
            parse_ph = PH_DONE;
    endtask

    task automatic close_unit();
        if (!rec_pending)
            parse_ph = PH_LEN0;
        else
        begin
            if (sets_left != 0)
                sets_left = sets_left - 5'd1;
            next_set();
        end
    endtask

    task automatic push_start_code(ref stream_beat_t q [$]);
        q.push_back('{stream_byte: START_ZERO, unit_begin: 1'b1, run_last: 1'b0});
        q.push_back('{stream_byte: START_ZERO, unit_begin: 1'b0, run_last: 1'b0});
        q.push_back('{stream_byte: START_ZERO, unit_begin: 1'b0, run_last: 1'b0});
        q.push_back('{stream_byte: START_ONE,  unit_begin: 1'b0, run_last: 1'b1});
    endtask

    task automatic convert_body_byte(input body_beat_t b);
        logic [23:0] plen;
        logic [23:0] at;
        plen = b.packet_length;
        at   = at_pos;
        step_results = {};
        if (plen >= MIN_PACKET && at < plen)
        begin
            case (parse_ph)
                PH_SKIP:
                begin
                    if (rec_pending)
                    begin
                        if (at + 1 >= CFG_SKIP)
                            parse_ph = PH_COUNT;
                    end
                    else if (at + 1 >= NALU_SKIP)
                        parse_ph = PH_LEN0;
                end
                PH_COUNT:
                begin
                    sets_left = b.body_byte[4:0] & SET_COUNT_MASK;
                    next_set();
                end
                PH_LEN0:
                begin
                    len_acc  = {24'd0, b.body_byte};
                    parse_ph = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_acc  = {len_acc[23:0], b.body_byte};
                    parse_ph = PH_LEN2;
                end
                PH_LEN2:
                begin
                    if (rec_pending)
                        len_acc = {24'd0, b.body_byte};
                    else
                        len_acc = {len_acc[23:0], b.body_byte};
                    parse_ph = PH_LEN3;
                end
                PH_LEN3:
                begin
                    len_acc  = {len_acc[23:0], b.body_byte};
                    push_start_code(step_results);
                    pay_left = len_acc;
                    if (pay_left == 0)
                        close_unit();
                    else
                        parse_ph = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    step_results.push_back('{stream_byte: b.body_byte, unit_begin: 1'b0,
                                             run_last: 1'b1});
                    pay_left = pay_left - 32'd1;
                    if (pay_left == 0)
                        close_unit();
                end
                default:
                begin
                end
            endcase
        end
        if (b.packet_end)
        begin
            if (plen >= MIN_PACKET)
                rec_pending = 1'b0;
            clear_parser();
        end
        else if (at != MAX_POS)
            at_pos = at + 24'd1;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input body_beat_t b, input row_kind_t kind);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            body_valid <= 1'b0;
            @(negedge clk);
        end
        body       <= b;
        body_valid <= 1'b1;
        @(posedge clk);
        while (!body_ready)
            @(posedge clk);
        convert_body_byte(b);
        case (kind)
            ROW_NONE:
            begin
            end
            ROW_START:
                push_start_code(stream_expected);
            default:
                foreach (step_results[i])
                    stream_expected.push_back(step_results[i]);
        endcase
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic build_packet();
        int          pick;
        int          n_units;
        int          unit_len;
        int          count;
        int          cut;
        logic [23:0] plen;
        logic [7:0]  raw [$];
        raw  = {};
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            repeat (5)
                raw.push_back(8'($urandom_range(0, 255)));
            n_units = $urandom_range(1, 3);
            repeat (n_units)
            begin
                if ($urandom_range(0, 9) == 0)
                    unit_len = $urandom_range(7, 40);
                else
                    unit_len = $urandom_range(0, 6);
                raw.push_back(8'h00);
                raw.push_back(8'h00);
                raw.push_back(8'(unit_len >> 8));
                raw.push_back(8'(unit_len));
                repeat (unit_len)
                    raw.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, raw.size() - 6);
                repeat (cut)
                    void'(raw.pop_back());
            end
            count = raw.size();
            plen  = (count < MIN_PACKET) ? 24'(MIN_PACKET) : 24'(count);
            pick  = $urandom_range(0, 19);
            if (pick == 0)
                plen = MAX_POS;
            else if (pick == 1 && count > MIN_PACKET)
                plen = 24'($urandom_range(MIN_PACKET, count - 1));
        end
        else if (pick < 86)
        begin
            count = $urandom_range(1, 10);
            repeat (count)
                raw.push_back(8'($urandom_range(0, 255)));
            plen = 24'($urandom_range(0, MIN_PACKET - 1));
        end
        else
        begin
            count = $urandom_range(1, 24);
            repeat (count)
                raw.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
                plen = 24'($urandom);
            else
                plen = 24'($urandom_range(0, 30));
        end
        foreach (raw[i])
            packet_q.push_back('{body_byte: raw[i], packet_length: plen,
                                 packet_end: (i == raw.size() - 1)});
    endtask

    always @(negedge clk)
    begin
        stream_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        stream_beat_t exp_beat;
        if (stream_valid && stream_ready)
        begin
            if (stream_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected stream beat byte=%02h begin=%0b last=%0b",
                             $realtime, stream.stream_byte, stream.unit_begin,
                             stream.run_last);
            end
            else
            begin
                exp_beat = stream_expected.pop_front();
                beats_checked++;
                if (exp_beat.unit_begin)
                    start_codes++;
                if (stream.stream_byte !== exp_beat.stream_byte
                    || stream.unit_begin !== exp_beat.unit_begin
                    || stream.run_last !== exp_beat.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: beat %0d exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 $realtime, beats_checked, exp_beat.stream_byte,
                                 exp_beat.unit_begin, exp_beat.run_last,
                                 stream.stream_byte, stream.unit_begin, stream.run_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((body_valid && body_ready) || (stream_valid && stream_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int         ph;
        int         phase_start;
        body_beat_t row_beat;
        rec_pending = 1'b1;
        clear_parser();
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row_beat = '{body_byte: DIRECTED_ROWS[i].b, packet_length: DIRECTED_ROWS[i].len,
                         packet_end: DIRECTED_ROWS[i].last};
            send_beat(row_beat, DIRECTED_ROWS[i].kind);
        end
        packets_sent = 3;

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                build_packet();
                packets_sent++;
                while (packet_q.size() != 0)
                    send_beat(packet_q.pop_front(), ROW_PRED);
            end
        end
        body_valid <= 1'b0;

        while (stream_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d body beats in %0d packets, %0d stream beats with %0d start codes.",
                 beats_sent, packets_sent, beats_checked, start_codes);
        $display("Idle mixes: none, sender 51%%, receiver 51%%, both 34%%; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/avc_lp2sc_pkg.sv
hw/rtl/avc_length_prefixed_to_start_code_top.sv
tb/avc_length_prefixed_to_start_code_top_tb.sv
